/* design/tmwf_pkg.sv */
// tmwf_pkg: shared types, codes and side-selection functions for the triangle maze walker
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package tmwf_pkg;

    // fixed field widths
    localparam int unsigned CoordW  = 7;
    localparam int unsigned WallW   = 3;
    localparam int unsigned StatW   = 3;
    localparam int unsigned KindW   = 2;
    localparam int unsigned CfgAddrW = 4;
    localparam int unsigned CfgDataW = 32;

    typedef logic [CoordW-1:0] t_coord;
    typedef logic [WallW-1:0]  t_walls;
    typedef logic [StatW-1:0]  t_status;
    typedef logic [KindW-1:0]  t_kind;
    typedef logic [1:0]        t_side;

    // item kinds
    localparam t_kind KIND_LOAD  = 2'd0;
    localparam t_kind KIND_START = 2'd1;
    localparam t_kind KIND_STEP  = 2'd2;

    // sides of a cell
    localparam t_side SIDE_UD    = 2'd0;
    localparam t_side SIDE_RIGHT = 2'd1;
    localparam t_side SIDE_LEFT  = 2'd2;
    localparam t_side SIDE_NONE  = 2'd3;

    // result status codes
    localparam t_status STAT_OK      = 3'd0;
    localparam t_status STAT_PATH    = 3'd1;
    localparam t_status STAT_LAST    = 3'd2;
    localparam t_status STAT_REFUSED = 3'd3;
    localparam t_status STAT_NO_WALK = 3'd4;

    // register indexes on the config port
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_RULE = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_START,
        S_TURN,
        S_MOVE,
        S_DONE
    } t_state;

    // wall bit of one side: bit2 up/down, bit1 right, bit0 left
    function automatic logic wall_at(input t_walls w, input t_side s);
        logic b;
        case (s)
            SIDE_UD:    b = w[2];
            SIDE_RIGHT: b = w[1];
            SIDE_LEFT:  b = w[0];
            default:    b = 1'b1;
        endcase
        return b;
    endfunction

    // rotate by one or two sides, modulo three
    function automatic t_side side_advance(input t_side s, input logic two);
        t_side n;
        case (s)
            SIDE_UD:    n = two ? SIDE_LEFT  : SIDE_RIGHT;
            SIDE_RIGHT: n = two ? SIDE_UD    : SIDE_LEFT;
            SIDE_LEFT:  n = two ? SIDE_RIGHT : SIDE_UD;
            default:    n = two ? SIDE_LEFT  : SIDE_RIGHT;
        endcase
        return n;
    endfunction

    function automatic t_side side_first_col(input t_coord r, input logic lft,
                                             input t_walls w);
        if (w[0])
            return SIDE_NONE;
        return (lft == r[0]) ? SIDE_UD : SIDE_RIGHT;
    endfunction

    function automatic t_side side_last_col_even(input t_coord r, input logic lft,
                                                 input t_walls w);
        if (w[1])
            return SIDE_NONE;
        return (lft == r[0]) ? SIDE_UD : SIDE_LEFT;
    endfunction

    function automatic t_side side_last_col_odd(input t_coord r, input logic lft,
                                                input t_walls w);
        if (w[1])
            return SIDE_NONE;
        return (lft != r[0]) ? SIDE_UD : SIDE_LEFT;
    endfunction

    function automatic t_side side_last_row(input logic lft, input t_walls w);
        if (w[2])
            return SIDE_NONE;
        return lft ? SIDE_LEFT : SIDE_RIGHT;
    endfunction

    function automatic t_side side_first_row(input logic lft, input t_walls w);
        if (w[2])
            return SIDE_NONE;
        return lft ? SIDE_RIGHT : SIDE_LEFT;
    endfunction

    // position lies on the border where an entry side exists
    function automatic logic entry_cell(input t_coord r, input t_coord c,
                                        input t_coord rows, input t_coord cols);
        logic inner;
        inner = (c > 7'd1) && (c < cols);
        if (r != 7'd1 && c != 7'd1 && r != rows && c != cols)
            return 1'b0;
        if (r == 7'd1 && !c[0] && inner)
            return 1'b0;
        if (r == rows && rows[0] && c[0] && inner)
            return 1'b0;
        if (r == rows && !rows[0] && !c[0] && inner)
            return 1'b0;
        return 1'b1;
    endfunction

    // first side to try when entering at a border cell
    function automatic t_side entry_side(input t_coord r, input t_coord c,
                                         input t_coord rows, input t_coord cols,
                                         input logic lft, input t_walls w);
        t_side a;
        t_side b;
        if (r == 7'd1 && c != cols) begin
            b = side_first_col(r, lft, w);
            a = side_first_row(lft, w);
            if (a != SIDE_NONE)
                return a;
            if (c == 7'd1 && b != SIDE_NONE)
                return b;
            return SIDE_NONE;
        end
        if (r == rows && c != cols && c != 7'd1)
            return side_last_row(lft, w);
        if (c == 7'd1) begin
            b = side_last_row(lft, w);
            a = side_first_col(r, lft, w);
            if (a != SIDE_NONE)
                return a;
            if (r == rows && b != SIDE_NONE)
                return b;
            return SIDE_NONE;
        end
        if (c == cols && c[0]) begin
            a = side_last_col_odd(r, lft, w);
            if (a != SIDE_NONE)
                return a;
            if (r == 7'd1)
                return side_first_row(lft, w);
            if (r == rows)
                return side_last_row(lft, w);
            return SIDE_NONE;
        end
        a = side_last_col_even(r, lft, w);
        if (a != SIDE_NONE)
            return a;
        if (r == rows && r[0])
            return side_last_row(lft, w);
        return SIDE_NONE;
    endfunction

    // side to try first after moving through side s into the new cell
    function automatic t_side next_side(input logic same, input logic lft, input t_side s);
        logic to_right;
        logic to_left;
        if (same) begin
            to_right = (s == SIDE_UD && lft) || (s == SIDE_RIGHT && !lft);
            to_left  = (s == SIDE_UD && !lft) || (s == SIDE_LEFT && lft);
        end else begin
            to_right = (s == SIDE_UD && !lft) || (s == SIDE_RIGHT && lft);
            to_left  = (s == SIDE_UD && lft) || (s == SIDE_LEFT && !lft);
        end
        if (to_right)
            return SIDE_RIGHT;
        if (to_left)
            return SIDE_LEFT;
        return SIDE_UD;
    endfunction

endpackage

`default_nettype wire

/* design/tmwf_if.sv */
// tmwf_in_if / tmwf_out_if: valid-ready channels for input items and result words
// depends on tmwf_pkg for field types
`default_nettype none

interface tmwf_in_if;
    import tmwf_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  kind;
    t_coord row;
    t_coord col;
    t_walls cell_walls;

    modport source (output valid, output kind, output row, output col,
                    output cell_walls, input ready);
    modport sink   (input valid, input kind, input row, input col,
                    input cell_walls, output ready);
endinterface

interface tmwf_out_if;
    import tmwf_pkg::*;

    logic    valid;
    logic    ready;
    t_coord  out_row;
    t_coord  out_col;
    t_status status;

    modport source (output valid, output out_row, output out_col, output status,
                    input ready);
    modport sink   (input valid, input out_row, input out_col, input status,
                    output ready);
endinterface

`default_nettype wire

/* design/tmwf_ram.sv */
// tmwf_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module tmwf_ram #(
    parameter int unsigned WIDTH = 3,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re)
            o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/triangle_maze_wall_follower.sv */
// triangle_maze_wall_follower: loads a triangular-cell maze and walks it by a hand rule
// depends on tmwf_pkg, tmwf_in_if / tmwf_out_if and tmwf_ram
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------
//  i_in     | in  | valid / ready    | kind, row, col, cell_walls
//  o_out    | out | valid / ready    | out_row, out_col, status
//  apb      | in  | psel / penable   | paddr[3:0], pwdata, prdata
//
// one item at a time: a load, an unused kind or a step with no walk passes through the access
// and done states, a start adds a start state unless it lies outside the grid in use, and a walk
// step adds one pass of the turn state per wall test, up to three, plus a move state when a side is open
// ready is high only when idle; a finished word waits in the output register while the
// next item is taken, which stalls in its last cycle until that word is taken
// the cell store has one registered read port and is not cleared by the synchronous,
// active-low reset
`default_nettype none

module triangle_maze_wall_follower #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    tmwf_in_if.sink                                i_in,
    tmwf_out_if.source                             o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tmwf_pkg::CfgAddrW-1:0]     paddr,
    input  wire logic [tmwf_pkg::CfgDataW-1:0]     pwdata,
    output      logic [tmwf_pkg::CfgDataW-1:0]     prdata,
    output      logic                              pready
);

    import tmwf_pkg::*;

    localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
    localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

    // config registers
    t_coord r_rows, n_rows;
    t_coord r_cols, n_cols;
    logic   r_rule, n_rule;

    // sequencer and walk state
    t_state r_state, n_state;
    logic   r_walk_active, n_walk_active;
    t_coord r_cur_row, n_cur_row;
    t_coord r_cur_col, n_cur_col;
    t_side  r_cur_side, n_cur_side;
    t_side  r_side, n_side;
    logic [1:0] r_tries, n_tries;

    // latched item and pending result
    t_kind   r_kind, n_kind;
    t_coord  r_row, n_row;
    t_coord  r_col, n_col;
    t_walls  r_walls, n_walls;
    t_coord  r_res_row, n_res_row;
    t_coord  r_res_col, n_res_col;
    t_status r_res_stat, n_res_stat;

    // output register
    logic    r_out_valid, n_out_valid;
    t_coord  r_out_row, n_out_row;
    t_coord  r_out_col, n_out_col;
    t_status r_out_stat, n_out_stat;

    // memory signals
    logic             ram_we;
    logic             ram_re;
    logic [AddrW-1:0] ram_addr;
    t_walls           ram_rdata;

    // derived values
    t_coord      eff_rows;
    t_coord      eff_cols;
    logic        load_ok;
    logic        start_ok;
    t_coord      a_row;
    t_coord      a_col;
    logic [16:0] lin_addr;
    logic        cur_same;
    logic        long_turn;
    t_side       st_side;
    logic [7:0]  mv_row;
    logic [7:0]  mv_col;
    logic        mv_ok;
    logic        cfg_wr;

    // rows and columns in use, clipped to the store size
    assign eff_rows = ({2'b00, r_rows} > 9'(MAX_ROWS)) ? t_coord'(MAX_ROWS) : r_rows;
    assign eff_cols = ({2'b00, r_cols} > 9'(MAX_COLS)) ? t_coord'(MAX_COLS) : r_cols;

    assign load_ok  = (r_row != '0) && ({2'b00, r_row} <= 9'(MAX_ROWS)) &&
                      (r_col != '0) && ({2'b00, r_col} <= 9'(MAX_COLS));
    assign start_ok = (r_row != '0) && (r_row <= eff_rows) &&
                      (r_col != '0) && (r_col <= eff_cols);

    // cell address: (row-1)*MAX_COLS + (col-1)
    assign a_row    = (r_kind == KIND_STEP) ? r_cur_row : r_row;
    assign a_col    = (r_kind == KIND_STEP) ? r_cur_col : r_col;
    assign lin_addr = (17'(a_row) - 17'd1) * 17'(MAX_COLS) + 17'(a_col) - 17'd1;
    assign ram_addr = lin_addr[AddrW-1:0];

    assign ram_we = (r_state == S_ACCESS) && (r_kind == KIND_LOAD) && load_ok;
    assign ram_re = (r_state == S_ACCESS) &&
                    (((r_kind == KIND_START) && start_ok) ||
                     ((r_kind == KIND_STEP) && r_walk_active));

    tmwf_ram #(
        .WIDTH (WallW),
        .DEPTH (Depth)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (r_walls),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // turn size and start side
    assign cur_same  = ~(r_cur_row[0] ^ r_cur_col[0]);
    assign long_turn = cur_same != r_rule;
    assign st_side   = entry_side(r_row, r_col, eff_rows, eff_cols, r_rule, ram_rdata);

    // move through the chosen side
    always_comb begin
        mv_row = {1'b0, r_cur_row};
        mv_col = {1'b0, r_cur_col};
        case (r_side)
            SIDE_UD:    mv_row = cur_same ? ({1'b0, r_cur_row} - 8'd1)
                                          : ({1'b0, r_cur_row} + 8'd1);
            SIDE_RIGHT: mv_col = {1'b0, r_cur_col} + 8'd1;
            SIDE_LEFT:  mv_col = {1'b0, r_cur_col} - 8'd1;
            default:    mv_row = {1'b0, r_cur_row};
        endcase
    end
    assign mv_ok = (mv_row != '0) && (mv_row <= {1'b0, eff_rows}) &&
                   (mv_col != '0) && (mv_col <= {1'b0, eff_cols});

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_ROWS: prdata = {{(CfgDataW-CoordW){1'b0}}, r_rows};
            REG_COLS: prdata = {{(CfgDataW-CoordW){1'b0}}, r_cols};
            REG_RULE: prdata = {{(CfgDataW-1){1'b0}}, r_rule};
            default:  prdata = '0;
        endcase
    end

    // handshake outputs
    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.out_row = r_out_row;
    assign o_out.out_col = r_out_col;
    assign o_out.status  = r_out_stat;

    // next state and datapath
    always_comb begin
        n_state       = r_state;
        n_walk_active = r_walk_active;
        n_cur_row     = r_cur_row;
        n_cur_col     = r_cur_col;
        n_cur_side    = r_cur_side;
        n_side        = r_side;
        n_tries       = r_tries;
        n_kind        = r_kind;
        n_row         = r_row;
        n_col         = r_col;
        n_walls       = r_walls;
        n_res_row     = r_res_row;
        n_res_col     = r_res_col;
        n_res_stat    = r_res_stat;
        n_out_valid   = r_out_valid;
        n_out_row     = r_out_row;
        n_out_col     = r_out_col;
        n_out_stat    = r_out_stat;
        n_rows        = r_rows;
        n_cols        = r_cols;
        n_rule        = r_rule;

        // register writes
        if (cfg_wr && pready) begin
            case (paddr[3:2])
                REG_ROWS: n_rows = pwdata[CoordW-1:0];
                REG_COLS: n_cols = pwdata[CoordW-1:0];
                REG_RULE: n_rule = pwdata[0];
                default:  n_rule = r_rule;
            endcase
        end

        // output word taken
        if (o_out.ready)
            n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind  = i_in.kind;
                    n_row   = i_in.row;
                    n_col   = i_in.col;
                    n_walls = i_in.cell_walls;
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                n_res_row  = '0;
                n_res_col  = '0;
                n_res_stat = STAT_NO_WALK;
                n_state    = S_DONE;
                case (r_kind)
                    KIND_LOAD: begin
                        n_res_stat = STAT_OK;
                    end
                    KIND_START: begin
                        if (start_ok) begin
                            n_state = S_START;
                        end else begin
                            n_walk_active = 1'b0;
                            n_res_stat    = STAT_REFUSED;
                        end
                    end
                    KIND_STEP: begin
                        if (r_walk_active) begin
                            n_res_row = r_cur_row;
                            n_res_col = r_cur_col;
                            n_side    = r_cur_side;
                            n_tries   = '0;
                            n_state   = S_TURN;
                        end
                    end
                    default: begin
                        n_res_stat = STAT_NO_WALK;
                    end
                endcase
            end
            S_START: begin
                n_state = S_DONE;
                if (st_side == SIDE_NONE ||
                    !entry_cell(r_row, r_col, eff_rows, eff_cols)) begin
                    n_walk_active = 1'b0;
                    n_res_stat    = STAT_REFUSED;
                end else begin
                    n_cur_row     = r_row;
                    n_cur_col     = r_col;
                    n_cur_side    = st_side;
                    n_walk_active = 1'b1;
                    n_res_stat    = STAT_OK;
                end
            end
            // one wall test per cycle, turning while walled
            S_TURN: begin
                if (!wall_at(ram_rdata, r_side)) begin
                    n_state = S_MOVE;
                end else if (r_tries == 2'd2) begin
                    n_walk_active = 1'b0;
                    n_res_stat    = STAT_LAST;
                    n_state       = S_DONE;
                end else begin
                    n_side  = side_advance(r_side, long_turn);
                    n_tries = r_tries + 2'd1;
                end
            end
            S_MOVE: begin
                n_state = S_DONE;
                if (mv_ok) begin
                    n_cur_row  = mv_row[CoordW-1:0];
                    n_cur_col  = mv_col[CoordW-1:0];
                    n_cur_side = next_side(~(mv_row[0] ^ mv_col[0]), r_rule, r_side);
                    n_res_stat = STAT_PATH;
                end else begin
                    n_walk_active = 1'b0;
                    n_res_stat    = STAT_LAST;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_res_row;
                    n_out_col   = r_res_col;
                    n_out_stat  = r_res_stat;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_walk_active <= 1'b0;
            r_cur_row     <= '0;
            r_cur_col     <= '0;
            r_cur_side    <= SIDE_UD;
            r_out_valid   <= 1'b0;
            r_rows        <= 7'd1;
            r_cols        <= 7'd1;
            r_rule        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_walk_active <= n_walk_active;
            r_cur_row     <= n_cur_row;
            r_cur_col     <= n_cur_col;
            r_cur_side    <= n_cur_side;
            r_out_valid   <= n_out_valid;
            r_rows        <= n_rows;
            r_cols        <= n_cols;
            r_rule        <= n_rule;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_side     <= n_side;
        r_tries    <= n_tries;
        r_kind     <= n_kind;
        r_row      <= n_row;
        r_col      <= n_col;
        r_walls    <= n_walls;
        r_res_row  <= n_res_row;
        r_res_col  <= n_res_col;
        r_res_stat <= n_res_stat;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_stat <= n_out_stat;
    end

endmodule

`default_nettype wire

/* design/tmwf_checker.sv */
// tmwf_checker: port-level assertions for the triangle maze walker, bound to the top level
// depends on tmwf_pkg and triangle_maze_wall_follower
`default_nettype none

module tmwf_checker (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire tmwf_pkg::t_coord      i_out_row,
    input wire tmwf_pkg::t_coord      i_out_col,
    input wire tmwf_pkg::t_status     i_out_status
);

    import tmwf_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_row) && $stable(i_out_col) && $stable(i_out_status))
        else $error("result word changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after an accept");

    // words without a cell carry zero position
    a_no_cell_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == STAT_OK || i_out_status == STAT_REFUSED ||
                        i_out_status == STAT_NO_WALK)
            |-> i_out_row == '0 && i_out_col == '0)
        else $error("position reported on a word without a cell");

    // path and last-cell words name a real cell
    a_path_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == STAT_PATH || i_out_status == STAT_LAST)
            |-> i_out_row != '0 && i_out_col != '0)
        else $error("walk word without a cell position");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

endmodule

bind triangle_maze_wall_follower tmwf_checker u_tmwf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_row    (o_out.out_row),
    .i_out_col    (o_out.out_col),
    .i_out_status (o_out.status)
);

`default_nettype wire
